>>> sv/tlpq_pkg.sv
// Package for the two-level priority trigger queue.
// Holds queue sizing constants, command/status codes, transaction structs
// and the ring index helper. No dependencies.
package tlpq_pkg;

  // Queue sizing
  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_RESULTS = 32;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W       = CNT_W + 1;
  localparam int TOT_CAP     = (2 * QUEUE_DEPTH < MAX_RESULTS) ? 2 * QUEUE_DEPTH : MAX_RESULTS;
  localparam int TOT_W       = $clog2(TOT_CAP + 1);
  localparam int KIND_W      = 8;
  localparam int HANDLE_W    = 16;
  localparam int ENTRY_W     = KIND_W + HANDLE_W;

  typedef enum logic [1:0] {
    CMD_PUSH_NORMAL   = 2'd0,
    CMD_PUSH_PRIORITY = 2'd1,
    CMD_POP           = 2'd2,
    CMD_SNAPSHOT      = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_SNAP_RD,
    S_SNAP_OUT
  } state_t;

  typedef struct packed {
    cmd_t                command;
    logic [KIND_W-1:0]   trigger_kind;
    logic [HANDLE_W-1:0] payload_handle;
  } tlpq_in_t;

  typedef struct packed {
    status_t             status;
    logic [KIND_W-1:0]   out_kind;
    logic [HANDLE_W-1:0] out_handle;
    logic                from_priority;
    logic                last_item;
  } tlpq_out_t;

  // Fold a head-plus-offset sum (always below twice the depth) into the ring
  function automatic logic [IDX_W-1:0] wrap_idx(input logic [SUM_W-1:0] sum);
    logic [SUM_W-1:0] folded;
    folded = sum;
    if (sum >= SUM_W'(QUEUE_DEPTH)) begin
      folded = sum - SUM_W'(QUEUE_DEPTH);
    end
    return folded[IDX_W-1:0];
  endfunction

endpackage

>>> sv/tlpq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; used for both entry stores of the trigger queue.
module tlpq_ram #(
  parameter int DEPTH  = 16,
  parameter int WIDTH  = 24,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/two_level_priority_trigger_queue.sv
// Two-level strict-priority trigger queue.
// Uses tlpq_pkg and two tlpq_ram instances (priority store, normal store).
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one command per
//   transaction: push normal, push priority, pop or snapshot. Result channel
//   (out_valid / out_stall / out_data) returns the results; last_item marks
//   the final result of each command.
// Command flow:
//   Push: result registered in the cycle after acceptance; a push can be taken
//   every cycle while the receiver keeps up.
//   Pop: the store read is registered, then the entry is loaded into the
//   output register; no new command is taken until the pop is done.
//   Snapshot: each listed entry takes a store read, then an output load,
//   one entry at a time; at most MAX_RESULTS results.
//   The next command is taken once the last result of the current one sits
//   in the output register and that register can move on.
// Reset: heads and counts clear, both queues read as empty; store contents
//   are not cleared and need no clearing pass.
// Stall: a stalled result holds in the output register; the output load of
//   the sequencer and the input channel wait until it is taken.
module two_level_priority_trigger_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tlpq_pkg::tlpq_in_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tlpq_pkg::tlpq_out_t out_data
);

  import tlpq_pkg::*;

  // Control registers
  state_t           state_r,     state_nxt;
  logic [IDX_W-1:0] ph_r,        ph_nxt;
  logic [CNT_W-1:0] pc_r,        pc_nxt;
  logic [IDX_W-1:0] nh_r,        nh_nxt;
  logic [CNT_W-1:0] nc_r,        nc_nxt;
  logic [TOT_W-1:0] idx_r,       idx_nxt;
  logic [TOT_W-1:0] total_r,     total_nxt;
  logic             sel_pri_r,   sel_pri_nxt;
  logic             out_valid_r, out_valid_nxt;
  tlpq_out_t        out_data_r,  out_data_nxt;

  // Store ports
  logic               p_wr_en, n_wr_en, p_rd_en, n_rd_en;
  logic [IDX_W-1:0]   p_wr_addr, n_wr_addr, p_rd_addr, n_rd_addr;
  logic [ENTRY_W-1:0] wr_entry, p_rd_data, n_rd_data, rd_entry;

  // Working values
  logic             out_free;
  logic             accept;
  logic [SUM_W-1:0] count_sum;
  logic [SUM_W-1:0] idx_ext;
  logic             snap_in_pri;
  logic [SUM_W-1:0] snap_off;
  logic             snap_last;

  tlpq_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(ENTRY_W)) u_pri_ram (
    .clk     (clk),
    .wr_en   (p_wr_en),
    .wr_addr (p_wr_addr),
    .wr_data (wr_entry),
    .rd_en   (p_rd_en),
    .rd_addr (p_rd_addr),
    .rd_data (p_rd_data)
  );

  tlpq_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(ENTRY_W)) u_nrm_ram (
    .clk     (clk),
    .wr_en   (n_wr_en),
    .wr_addr (n_wr_addr),
    .wr_data (wr_entry),
    .rd_en   (n_rd_en),
    .rd_addr (n_rd_addr),
    .rd_data (n_rd_data)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == S_IDLE) && out_free);
  assign accept    = in_valid && !in_stall;
  assign wr_entry  = {in_data.trigger_kind, in_data.payload_handle};
  assign rd_entry  = sel_pri_r ? p_rd_data : n_rd_data;
  assign count_sum = SUM_W'(pc_r) + SUM_W'(nc_r);

  // Snapshot walk: priority entries first, then normal entries
  assign idx_ext     = SUM_W'(idx_r);
  assign snap_in_pri = idx_ext < SUM_W'(pc_r);
  assign snap_off    = snap_in_pri ? idx_ext : idx_ext - SUM_W'(pc_r);
  assign snap_last   = (idx_r + TOT_W'(1)) == total_r;

  // Sequencer: next state, queue pointers, store accesses and result load
  always_comb begin
    state_nxt     = state_r;
    ph_nxt        = ph_r;
    pc_nxt        = pc_r;
    nh_nxt        = nh_r;
    nc_nxt        = nc_r;
    idx_nxt       = idx_r;
    total_nxt     = total_r;
    sel_pri_nxt   = sel_pri_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    p_wr_en       = 1'b0;
    n_wr_en       = 1'b0;
    p_rd_en       = 1'b0;
    n_rd_en       = 1'b0;
    p_wr_addr     = wrap_idx(SUM_W'(ph_r) + SUM_W'(pc_r));
    n_wr_addr     = wrap_idx(SUM_W'(nh_r) + SUM_W'(nc_r));
    p_rd_addr     = ph_r;
    n_rd_addr     = nh_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_data_nxt  = '{status: ST_OK, out_kind: '0, out_handle: '0,
                            from_priority: 1'b0, last_item: 1'b1};
          unique case (in_data.command)
            CMD_PUSH_NORMAL: begin
              out_valid_nxt = 1'b1;
              if (nc_r == CNT_W'(QUEUE_DEPTH)) begin
                out_data_nxt.status = ST_FULL;
              end else begin
                n_wr_en = 1'b1;
                nc_nxt  = nc_r + CNT_W'(1);
              end
            end
            CMD_PUSH_PRIORITY: begin
              out_valid_nxt = 1'b1;
              if (pc_r == CNT_W'(QUEUE_DEPTH)) begin
                out_data_nxt.status = ST_FULL;
              end else begin
                p_wr_en = 1'b1;
                pc_nxt  = pc_r + CNT_W'(1);
              end
            end
            CMD_POP: begin
              if (pc_r != '0) begin
                p_rd_en     = 1'b1;
                sel_pri_nxt = 1'b1;
                ph_nxt      = wrap_idx(SUM_W'(ph_r) + SUM_W'(1));
                pc_nxt      = pc_r - CNT_W'(1);
                state_nxt   = S_POP;
              end else if (nc_r != '0) begin
                n_rd_en     = 1'b1;
                sel_pri_nxt = 1'b0;
                nh_nxt      = wrap_idx(SUM_W'(nh_r) + SUM_W'(1));
                nc_nxt      = nc_r - CNT_W'(1);
                state_nxt   = S_POP;
              end else begin
                out_valid_nxt       = 1'b1;
                out_data_nxt.status = ST_EMPTY;
              end
            end
            CMD_SNAPSHOT: begin
              if (count_sum == '0) begin
                out_valid_nxt       = 1'b1;
                out_data_nxt.status = ST_EMPTY;
              end else begin
                idx_nxt   = '0;
                total_nxt = (count_sum > SUM_W'(TOT_CAP)) ? TOT_W'(TOT_CAP)
                                                          : TOT_W'(count_sum);
                state_nxt = S_SNAP_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_POP: begin
        // Output register was drained at acceptance; load the popped entry
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{status: ST_OK, out_kind: rd_entry[ENTRY_W-1:HANDLE_W],
                          out_handle: rd_entry[HANDLE_W-1:0],
                          from_priority: sel_pri_r, last_item: 1'b1};
        state_nxt     = S_IDLE;
      end
      S_SNAP_RD: begin
        sel_pri_nxt = snap_in_pri;
        if (snap_in_pri) begin
          p_rd_en   = 1'b1;
          p_rd_addr = wrap_idx(SUM_W'(ph_r) + snap_off);
        end else begin
          n_rd_en   = 1'b1;
          n_rd_addr = wrap_idx(SUM_W'(nh_r) + snap_off);
        end
        state_nxt = S_SNAP_OUT;
      end
      S_SNAP_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status: ST_OK, out_kind: rd_entry[ENTRY_W-1:HANDLE_W],
                            out_handle: rd_entry[HANDLE_W-1:0],
                            from_priority: sel_pri_r, last_item: snap_last};
          if (snap_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + TOT_W'(1);
            state_nxt = S_SNAP_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ph_r        <= '0;
      pc_r        <= '0;
      nh_r        <= '0;
      nc_r        <= '0;
      idx_r       <= '0;
      total_r     <= '0;
      sel_pri_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ph_r        <= ph_nxt;
      pc_r        <= pc_nxt;
      nh_r        <= nh_nxt;
      nc_r        <= nc_nxt;
      idx_r       <= idx_nxt;
      total_r     <= total_nxt;
      sel_pri_r   <= sel_pri_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload, no reset
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> sv/tlpq_checker.sv
// Port-level checks for the two-level priority trigger queue.
// Uses tlpq_pkg; bound to two_level_priority_trigger_queue at the end of file.
module tlpq_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input tlpq_pkg::tlpq_in_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input tlpq_pkg::tlpq_out_t out_data
);

  import tlpq_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // A push answers in the next cycle with a single final result
  a_push_resp: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall &&
    (in_data.command == CMD_PUSH_NORMAL || in_data.command == CMD_PUSH_PRIORITY)
    |=> out_valid && out_data.last_item && !out_data.from_priority &&
        out_data.out_handle == '0 && out_data.out_kind == '0)
    else $error("push result malformed or late");

  // An empty report carries a null entry and ends the command
  a_empty_null: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_EMPTY
    |-> out_data.out_handle == '0 && out_data.out_kind == '0 &&
        !out_data.from_priority && out_data.last_item)
    else $error("empty result carries an entry");

  // A dropped push only ever comes with a final result
  a_full_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_FULL |-> out_data.last_item)
    else $error("full status on a non-final result");

endmodule

bind two_level_priority_trigger_queue tlpq_checker u_tlpq_checker (.*);

>>> dv/two_level_priority_trigger_queue_tb.sv
// Self-checking testbench for the two-level priority trigger queue.
// Needs tlpq_pkg and two_level_priority_trigger_queue; a scoreboard class mirrors
// both rings and checks every result transaction in order.
module two_level_priority_trigger_queue_tb;
  import tlpq_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam int MAX_REPORTED  = 10;
  localparam int RANDOM_ITEMS  = 480;

  typedef enum int {
    BURST_FILL,
    BURST_DRAIN,
    BURST_MIXED
  } burst_mode_t;

  // Mirror of both rings plus the queue of results still owed by the block
  class trigger_queue_scoreboard;
    tlpq_out_t          owed_results[$];
    logic [ENTRY_W-1:0] priority_ring [QUEUE_DEPTH];
    logic [ENTRY_W-1:0] normal_ring [QUEUE_DEPTH];
    int                 priority_head;
    int                 priority_fill;
    int                 normal_head;
    int                 normal_fill;
    int                 mismatches;
    bit                 failed;

    // Append one owed result behind the others
    function void owe_result(tlpq_out_t res);
      owed_results.insert(owed_results.size(), res);
    endfunction

    // Remove and return the oldest owed result
    function tlpq_out_t take_oldest();
      tlpq_out_t oldest;
      oldest = owed_results[0];
      owed_results.delete(0);
      return oldest;
    endfunction

    // Work out every result one accepted command causes
    function void note_command(tlpq_in_t cmd);
      tlpq_out_t res;
      int        listed;
      res           = '0;
      res.status    = ST_OK;
      res.last_item = 1'b1;
      case (cmd.command)
        CMD_PUSH_NORMAL: begin
          if (normal_fill >= QUEUE_DEPTH) begin
            res.status = ST_FULL;
          end else begin
            normal_ring[(normal_head + normal_fill) % QUEUE_DEPTH] =
              {cmd.trigger_kind, cmd.payload_handle};
            normal_fill++;
          end
          owe_result(res);
        end
        CMD_PUSH_PRIORITY: begin
          if (priority_fill >= QUEUE_DEPTH) begin
            res.status = ST_FULL;
          end else begin
            priority_ring[(priority_head + priority_fill) % QUEUE_DEPTH] =
              {cmd.trigger_kind, cmd.payload_handle};
            priority_fill++;
          end
          owe_result(res);
        end
        CMD_POP: begin
          // Serve the priority ring first, fall back to the normal ring
          if (priority_fill != 0) begin
            {res.out_kind, res.out_handle} = priority_ring[priority_head];
            res.from_priority = 1'b1;
            priority_head = (priority_head + 1) % QUEUE_DEPTH;
            priority_fill--;
          end else if (normal_fill != 0) begin
            {res.out_kind, res.out_handle} = normal_ring[normal_head];
            normal_head = (normal_head + 1) % QUEUE_DEPTH;
            normal_fill--;
          end else begin
            res.status = ST_EMPTY;
          end
          owe_result(res);
        end
        CMD_SNAPSHOT: begin
          listed = priority_fill + normal_fill;
          if (listed == 0) begin
            res.status = ST_EMPTY;
            owe_result(res);
          end else begin
            if (listed > MAX_RESULTS) begin
              listed = MAX_RESULTS;
            end
            // List priority entries oldest first, then normal entries
            for (int i = 0; i < listed; i++) begin
              res.last_item = (i == listed - 1);
              if (i < priority_fill) begin
                {res.out_kind, res.out_handle} =
                  priority_ring[(priority_head + i) % QUEUE_DEPTH];
                res.from_priority = 1'b1;
              end else begin
                {res.out_kind, res.out_handle} =
                  normal_ring[(normal_head + i - priority_fill) % QUEUE_DEPTH];
                res.from_priority = 1'b0;
              end
              owe_result(res);
            end
          end
        end
      endcase
    endfunction

    // Compare one result transaction with the oldest owed result
    function void check_result(tlpq_out_t got);
      tlpq_out_t want;
      if (owed_results.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= MAX_REPORTED) begin
          $display("unexpected result: status=%0d kind=%02h handle=%04h prio=%0b last=%0b",
                   got.status, got.out_kind, got.out_handle, got.from_priority,
                   got.last_item);
        end
        return;
      end
      want = take_oldest();
      if (got.status !== want.status || got.out_kind !== want.out_kind ||
          got.out_handle !== want.out_handle ||
          got.from_priority !== want.from_priority ||
          got.last_item !== want.last_item) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= MAX_REPORTED) begin
          $display("mismatch: expected status=%0d kind=%02h handle=%04h prio=%0b last=%0b",
                   want.status, want.out_kind, want.out_handle, want.from_priority,
                   want.last_item);
          $display("          actual   status=%0d kind=%02h handle=%04h prio=%0b last=%0b",
                   got.status, got.out_kind, got.out_handle, got.from_priority,
                   got.last_item);
        end
      end
    endfunction

    function void note_leftover();
      if (owed_results.size() != 0) begin
        failed = 1'b1;
        $display("%0d results never arrived", owed_results.size());
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  tlpq_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  tlpq_out_t out_data;

  int        send_idle_pct = 0;
  int        stall_pct = 0;
  int        cycle_count = 0;

  trigger_queue_scoreboard sb;

  two_level_priority_trigger_queue DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Observe both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_stall === 1'b0) begin
        sb.note_command(in_data);
      end
      if (out_valid && out_stall === 1'b0) begin
        sb.check_result(out_data);
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Present one command transaction; entered and left at a falling edge
  task automatic drive_command(input cmd_t cmd, input logic [KIND_W-1:0] kind,
                               input logic [HANDLE_W-1:0] handle);
    tlpq_in_t item;
    int       gap;
    item.command        = cmd;
    item.trigger_kind   = kind;
    item.payload_handle = handle;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) begin
      gap++;
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall !== 1'b0) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  // Empty cases, field extremes, priority overflow, listing and pop order
  task automatic run_directed();
    int i;
    drive_command(CMD_POP, 8'h00, 16'h0000);
    drive_command(CMD_SNAPSHOT, 8'hFF, 16'hFFFF);
    drive_command(CMD_PUSH_NORMAL, 8'h00, 16'h0000);
    drive_command(CMD_PUSH_NORMAL, 8'hFF, 16'hFFFF);
    // One push beyond capacity, which must be dropped
    for (i = 0; i <= QUEUE_DEPTH; i++) begin
      drive_command(CMD_PUSH_PRIORITY, 8'(8'hA5 ^ i), 16'(16'h5A5A ^ (i * 16'h1111)));
    end
    drive_command(CMD_SNAPSHOT, 8'h00, 16'h0000);
    drive_command(CMD_POP, 8'hFF, 16'hFFFF);
    drive_command(CMD_POP, 8'h00, 16'h0000);
  endtask

  function automatic tlpq_in_t random_command(burst_mode_t mode, bit to_priority);
    tlpq_in_t item;
    int       roll;
    roll = $urandom_range(99);
    item.trigger_kind   = 8'($urandom_range(255));
    item.payload_handle = 16'($urandom_range(65535));
    case ($urandom_range(7))
      0: begin
        item.trigger_kind   = '0;
        item.payload_handle = '0;
      end
      1: begin
        item.trigger_kind   = '1;
        item.payload_handle = '1;
      end
      default: ;
    endcase
    if (roll < 8) begin
      item.command = CMD_SNAPSHOT;
    end else begin
      case (mode)
        BURST_FILL: begin
          if (roll < 80) begin
            item.command = to_priority ? CMD_PUSH_PRIORITY : CMD_PUSH_NORMAL;
          end else if (roll < 90) begin
            item.command = to_priority ? CMD_PUSH_NORMAL : CMD_PUSH_PRIORITY;
          end else begin
            item.command = CMD_POP;
          end
        end
        BURST_DRAIN: begin
          if (roll < 80) begin
            item.command = CMD_POP;
          end else begin
            item.command = $urandom_range(1) ? CMD_PUSH_PRIORITY : CMD_PUSH_NORMAL;
          end
        end
        default: begin
          item.command = cmd_t'($urandom_range(2));
        end
      endcase
    end
    return item;
  endfunction

  // Bursts that fill, drain or mix, so both rings reach full and empty
  task automatic run_random(input int count);
    tlpq_in_t    item;
    burst_mode_t mode;
    bit          to_priority;
    int          burst_len;
    int          sent;
    sent = 0;
    while (sent < count) begin
      mode        = burst_mode_t'($urandom_range(2));
      to_priority = 1'($urandom_range(1));
      burst_len   = $urandom_range(24, 4);
      for (int n = 0; n < burst_len && sent < count; n++) begin
        item = random_command(mode, to_priority);
        drive_command(item.command, item.trigger_kind, item.payload_handle);
        sent++;
      end
    end
  endtask

  initial begin
    sb = new();
    send_idle_pct = 36;
    stall_pct     = 67;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    run_directed();
    run_random(RANDOM_ITEMS / 3);

    // Swap the idling of the two sides
    send_idle_pct = 67;
    stall_pct     = 36;
    run_random(RANDOM_ITEMS / 3);

    // Full rate on both sides
    send_idle_pct = 0;
    stall_pct     = 0;
    run_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
    in_valid <= 1'b0;

    // Drain owed results, then allow for stray late results
    while (sb.owed_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    sb.note_leftover();
    if (!sb.failed) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
